@@ sv/trta_pkg.sv @@
package trta_pkg;

    localparam int MAX_ITEMS      = 1024;
    localparam int SKILL_BITS     = 30;
    localparam int CFG_BITS       = 11;
    localparam int CFG_INDEX_BITS = 4;
    localparam int TOTAL_BITS     = 40;

    // address of one stored item, and a count that can hold MAX_ITEMS itself
    localparam int AW       = $clog2(MAX_ITEMS);
    localparam int CW       = $clog2(MAX_ITEMS + 1);
    localparam int SUM_BITS = SKILL_BITS + CW;
    localparam int KW       = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int LW       = AW + 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUP_A = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_GROUP_B = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [SKILL_BITS-1:0] first_skill;
        logic [SKILL_BITS-1:0] second_skill;
        logic                  last_item;
    } item_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] best_total;
        logic                  overflowed;
    } result_t;

    typedef struct packed {
        logic [SKILL_BITS-1:0] first;
        logic [SKILL_BITS-1:0] second;
    } pair_t;

    typedef struct packed {
        logic                  clear;
        logic                  add;
        logic [SKILL_BITS-1:0] value;
        logic [CFG_BITS-1:0]   keep;
    } heap_cmd_t;

    typedef struct packed {
        logic                done;
        logic [SUM_BITS-1:0] sum;
    } heap_sts_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_CHECK,
        ST_MSETUP,
        ST_MHEADI,
        ST_MHEADJ,
        ST_MSTEP,
        ST_MFETCH,
        ST_PINIT,
        ST_PREAD,
        ST_PGET,
        ST_PWAIT,
        ST_PSTORE,
        ST_SINIT,
        ST_SCHECK,
        ST_SCAND,
        ST_SNEXT,
        ST_FINISH
    } ctl_state_t;

    typedef enum logic [3:0] {
        HS_IDLE,
        HS_UP,
        HS_UPCMP,
        HS_ROOT,
        HS_ADDV,
        HS_DN,
        HS_DNL,
        HS_DNR,
        HS_DNSEL,
        HS_DONE
    } heap_state_t;

endpackage

@@ sv/two_role_topk_assignment_top.sv @@
// Channel   Dir  Handshake                 Payload
// item      in   item_valid/item_ready     trta_pkg::item_t (first, second skill, last flag)
// result    out  result_valid/result_ready trta_pkg::result_t (best_total, overflowed)
// cfg       in   cfg_valid/cfg_ready       cfg_index, cfg_data (group sizes)
//
// Loading accepts one item per cycle. The last item starts the compute; item_ready
// stays low until it ends. Merge sort runs in ping-pong banks (log2(n) passes); then
// a prefix heap pass and a suffix heap pass run on the single heap.
// Reset is asynchronous; no clearing pass, stores are only read where written.
// A held result does not stall loading; only finishing a set waits for it.
module two_role_topk_assignment_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  trta_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_ready,
    output trta_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [trta_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [trta_pkg::CFG_BITS-1:0]       cfg_data
);

    trta_pkg::ctl_state_t state_reg, state_next;

    // set bookkeeping
    logic [trta_pkg::CW-1:0]       count_reg, count_next;
    logic                          ovf_reg, ovf_next;
    logic [trta_pkg::CFG_BITS-1:0] grp_a_reg, grp_a_next;
    logic [trta_pkg::CFG_BITS-1:0] grp_b_reg, grp_b_next;

    // merge sort sequencer
    logic                          src_reg, src_next;
    logic [trta_pkg::CW:0]         width_reg, width_next;
    logic [trta_pkg::CW-1:0]       lo_reg, lo_next;
    logic [trta_pkg::CW-1:0]       mid_reg, mid_next;
    logic [trta_pkg::CW-1:0]       hi_reg, hi_next;
    logic [trta_pkg::CW-1:0]       i_reg, i_next;
    logic [trta_pkg::CW-1:0]       j_reg, j_next;
    logic [trta_pkg::CW-1:0]       k_reg, k_next;
    logic                          sel_j_reg, sel_j_next;
    trta_pkg::pair_t               head_i_reg, head_i_next;
    trta_pkg::pair_t               head_j_reg, head_j_next;

    // heap passes and result
    logic                          pass_reg, pass_next;
    logic [trta_pkg::SUM_BITS-1:0] best_reg, best_next;
    trta_pkg::result_t             res_reg, res_next;
    logic                          res_valid_reg, res_valid_next;

    // bank RAMs
    logic                    b_we;
    logic                    b_wsel;
    logic [trta_pkg::AW-1:0] b_waddr;
    trta_pkg::pair_t         b_wdata;
    logic [trta_pkg::AW-1:0] rd_addr;
    trta_pkg::pair_t         rdata0, rdata1, src_data;

    // prefix RAM
    logic                          p_we;
    logic [trta_pkg::CW-1:0]       p_waddr;
    logic [trta_pkg::SUM_BITS-1:0] p_wdata;
    logic [trta_pkg::CW-1:0]       p_raddr;
    logic [trta_pkg::SUM_BITS-1:0] p_rdata;

    trta_pkg::heap_cmd_t heap_cmd;
    trta_pkg::heap_sts_t heap_sts;

    logic                              item_accept;
    logic [trta_pkg::CW+1:0]           n_ext;
    logic [trta_pkg::CW+1:0]           lo_w;
    logic [trta_pkg::CW+1:0]           lo_2w;
    logic [trta_pkg::CW+1:0]           w2;
    logic signed [trta_pkg::SKILL_BITS:0] key_i, key_j;
    logic                              act_i, act_j, take_j;
    logic                              too_few;
    logic                              split_ok;
    logic [trta_pkg::CW-1:0]           i_inc, k_dec;
    logic [trta_pkg::SUM_BITS-1:0]     cand;

    assign item_ready  = (state_reg == trta_pkg::ST_LOAD);
    assign item_accept = item_valid && item_ready;
    assign cfg_ready   = 1'b1;

    assign n_ext = (trta_pkg::CW + 2)'(count_reg);
    assign lo_w  = (trta_pkg::CW + 2)'(lo_reg) + (trta_pkg::CW + 2)'(width_reg);
    assign w2    = (trta_pkg::CW + 2)'(width_reg) << 1;
    assign lo_2w = (trta_pkg::CW + 2)'(lo_reg) + w2;

    // sort key: first minus second, descending
    assign key_i = $signed({1'b0, head_i_reg.first}) - $signed({1'b0, head_i_reg.second});
    assign key_j = $signed({1'b0, head_j_reg.first}) - $signed({1'b0, head_j_reg.second});
    assign act_i  = i_reg < mid_reg;
    assign act_j  = j_reg < hi_reg;
    assign take_j = act_j && (!act_i || (key_j > key_i));

    assign too_few = ((trta_pkg::KW + 1)'(grp_a_reg) + (trta_pkg::KW + 1)'(grp_b_reg))
                     > (trta_pkg::KW + 1)'(count_reg);
    assign split_ok = (trta_pkg::KW'(k_reg) >= trta_pkg::KW'(grp_a_reg)) &&
                      (trta_pkg::KW'(count_reg - k_reg) >= trta_pkg::KW'(grp_b_reg));
    assign i_inc = i_reg + trta_pkg::CW'(1);
    assign k_dec = k_reg - trta_pkg::CW'(1);
    assign cand  = p_rdata + heap_sts.sum;

    assign src_data = src_reg ? rdata1 : rdata0;

    trta_ram #(
        .WIDTH(2 * trta_pkg::SKILL_BITS),
        .DEPTH(trta_pkg::MAX_ITEMS)
    ) u_bank0 (
        .clk   (clk),
        .we    (b_we && !b_wsel),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (rd_addr),
        .rdata (rdata0)
    );

    trta_ram #(
        .WIDTH(2 * trta_pkg::SKILL_BITS),
        .DEPTH(trta_pkg::MAX_ITEMS)
    ) u_bank1 (
        .clk   (clk),
        .we    (b_we && b_wsel),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (rd_addr),
        .rdata (rdata1)
    );

    trta_ram #(
        .WIDTH(trta_pkg::SUM_BITS),
        .DEPTH(trta_pkg::MAX_ITEMS + 1)
    ) u_prefix (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    trta_heap u_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (heap_cmd),
        .sts   (heap_sts)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trta_pkg::ST_LOAD:
                if (item_accept && item.last_item)
                    state_next = trta_pkg::ST_CHECK;
            trta_pkg::ST_CHECK:
            begin
                if (too_few)
                    state_next = trta_pkg::ST_FINISH;
                else if (count_reg > trta_pkg::CW'(1))
                    state_next = trta_pkg::ST_MSETUP;
                else
                    state_next = trta_pkg::ST_PINIT;
            end
            trta_pkg::ST_MSETUP:
                state_next = trta_pkg::ST_MHEADI;
            trta_pkg::ST_MHEADI:
                state_next = trta_pkg::ST_MHEADJ;
            trta_pkg::ST_MHEADJ:
                state_next = trta_pkg::ST_MSTEP;
            trta_pkg::ST_MSTEP:
            begin
                if (act_i || act_j)
                    state_next = trta_pkg::ST_MFETCH;
                else if (lo_2w >= n_ext && w2 >= n_ext)
                    state_next = trta_pkg::ST_PINIT;
                else
                    state_next = trta_pkg::ST_MSETUP;
            end
            trta_pkg::ST_MFETCH:
                state_next = trta_pkg::ST_MSTEP;
            trta_pkg::ST_PINIT:
                state_next = trta_pkg::ST_PREAD;
            trta_pkg::ST_PREAD:
                state_next = trta_pkg::ST_PGET;
            trta_pkg::ST_PGET:
                state_next = trta_pkg::ST_PWAIT;
            trta_pkg::ST_PWAIT:
                if (heap_sts.done)
                    state_next = pass_reg ? trta_pkg::ST_SCHECK : trta_pkg::ST_PSTORE;
            trta_pkg::ST_PSTORE:
                state_next = (i_inc == count_reg) ? trta_pkg::ST_SINIT : trta_pkg::ST_PREAD;
            trta_pkg::ST_SINIT:
                state_next = trta_pkg::ST_SCHECK;
            trta_pkg::ST_SCHECK:
                state_next = split_ok ? trta_pkg::ST_SCAND : trta_pkg::ST_SNEXT;
            trta_pkg::ST_SCAND:
                state_next = trta_pkg::ST_SNEXT;
            trta_pkg::ST_SNEXT:
                state_next = (k_reg == '0) ? trta_pkg::ST_FINISH : trta_pkg::ST_PGET;
            trta_pkg::ST_FINISH:
                if (!res_valid_reg || result_ready)
                    state_next = trta_pkg::ST_LOAD;
            default:
                state_next = trta_pkg::ST_LOAD;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        grp_a_next     = grp_a_reg;
        grp_b_next     = grp_b_reg;
        src_next       = src_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        sel_j_next     = sel_j_reg;
        head_i_next    = head_i_reg;
        head_j_next    = head_j_reg;
        pass_next      = pass_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result_ready;

        b_we     = 1'b0;
        b_wsel   = !src_reg;
        b_waddr  = k_reg[trta_pkg::AW-1:0];
        b_wdata  = take_j ? head_j_reg : head_i_reg;
        rd_addr  = '0;
        p_we     = 1'b0;
        p_waddr  = i_inc;
        p_wdata  = heap_sts.sum;
        p_raddr  = k_reg;

        heap_cmd.clear = 1'b0;
        heap_cmd.add   = 1'b0;
        heap_cmd.value = pass_reg ? src_data.second : src_data.first;
        heap_cmd.keep  = pass_reg ? grp_b_reg : grp_a_reg;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                trta_pkg::REG_GROUP_A: grp_a_next = cfg_data;
                trta_pkg::REG_GROUP_B: grp_b_next = cfg_data;
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            trta_pkg::ST_LOAD:
            begin
                b_wsel         = 1'b0;
                b_waddr        = count_reg[trta_pkg::AW-1:0];
                b_wdata.first  = item.first_skill;
                b_wdata.second = item.second_skill;
                if (item_accept)
                begin
                    if (count_reg < trta_pkg::CW'(trta_pkg::MAX_ITEMS))
                    begin
                        b_we       = 1'b1;
                        count_next = count_reg + trta_pkg::CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            trta_pkg::ST_CHECK:
            begin
                best_next  = '0;
                src_next   = 1'b0;
                width_next = (trta_pkg::CW + 1)'(1);
                lo_next    = '0;
            end
            trta_pkg::ST_MSETUP:
            begin
                mid_next = (lo_w < n_ext) ? lo_w[trta_pkg::CW-1:0] : count_reg;
                hi_next  = (lo_2w < n_ext) ? lo_2w[trta_pkg::CW-1:0] : count_reg;
                i_next   = lo_reg;
                j_next   = (lo_w < n_ext) ? lo_w[trta_pkg::CW-1:0] : count_reg;
                k_next   = lo_reg;
                rd_addr  = lo_reg[trta_pkg::AW-1:0];
            end
            trta_pkg::ST_MHEADI:
            begin
                head_i_next = src_data;
                rd_addr     = j_reg[trta_pkg::AW-1:0];
            end
            trta_pkg::ST_MHEADJ:
                head_j_next = src_data;
            trta_pkg::ST_MSTEP:
            begin
                if (act_i || act_j)
                begin
                    b_we       = 1'b1;
                    k_next     = k_reg + trta_pkg::CW'(1);
                    sel_j_next = take_j;
                    if (take_j)
                    begin
                        j_next  = j_reg + trta_pkg::CW'(1);
                        rd_addr = trta_pkg::AW'(j_reg + trta_pkg::CW'(1));
                    end
                    else
                    begin
                        i_next  = i_inc;
                        rd_addr = i_inc[trta_pkg::AW-1:0];
                    end
                end
                else if (lo_2w >= n_ext)
                begin
                    // pass done: merged runs now live in the other bank
                    src_next   = !src_reg;
                    lo_next    = '0;
                    width_next = w2[trta_pkg::CW:0];
                end
                else
                begin
                    lo_next = lo_2w[trta_pkg::CW-1:0];
                end
            end
            trta_pkg::ST_MFETCH:
            begin
                if (sel_j_reg)
                    head_j_next = src_data;
                else
                    head_i_next = src_data;
            end
            trta_pkg::ST_PINIT:
            begin
                heap_cmd.clear = 1'b1;
                pass_next      = 1'b0;
                i_next         = '0;
                p_we           = 1'b1;
                p_waddr        = '0;
                p_wdata        = '0;
            end
            trta_pkg::ST_PREAD:
                rd_addr = i_reg[trta_pkg::AW-1:0];
            trta_pkg::ST_PGET:
                heap_cmd.add = 1'b1;
            trta_pkg::ST_PWAIT:
            begin
            end
            trta_pkg::ST_PSTORE:
            begin
                p_we   = 1'b1;
                i_next = i_inc;
            end
            trta_pkg::ST_SINIT:
            begin
                heap_cmd.clear = 1'b1;
                pass_next      = 1'b1;
                k_next         = count_reg;
            end
            trta_pkg::ST_SCHECK:
                p_raddr = k_reg;
            trta_pkg::ST_SCAND:
                if (cand > best_reg)
                    best_next = cand;
            trta_pkg::ST_SNEXT:
            begin
                k_next  = k_dec;
                rd_addr = k_dec[trta_pkg::AW-1:0];
            end
            trta_pkg::ST_FINISH:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next.best_total = trta_pkg::TOTAL_BITS'(best_reg);
                    res_next.overflowed = ovf_reg;
                    res_valid_next      = 1'b1;
                    count_next          = '0;
                    ovf_next            = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trta_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            grp_a_reg     <= trta_pkg::CFG_BITS'(1);
            grp_b_reg     <= trta_pkg::CFG_BITS'(1);
            res_valid_reg <= 1'b0;
            src_reg       <= 1'b0;
            pass_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            grp_a_reg     <= grp_a_next;
            grp_b_reg     <= grp_b_next;
            res_valid_reg <= res_valid_next;
            src_reg       <= src_next;
            pass_reg      <= pass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg  <= width_next;
        lo_reg     <= lo_next;
        mid_reg    <= mid_next;
        hi_reg     <= hi_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        sel_j_reg  <= sel_j_next;
        head_i_reg <= head_i_next;
        head_j_reg <= head_j_next;
        best_reg   <= best_next;
        res_reg    <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // stored count never passes capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= trta_pkg::CW'(trta_pkg::MAX_ITEMS))
        else $error("item count above capacity");

    // a closing item stops intake for the compute
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && item.last_item) |=> !item_ready)
        else $error("intake open after last item");

    // heap only reports completion while the sequencer waits on it
    a_heap_done: assert property (@(posedge clk) disable iff (!rst_n)
        heap_sts.done |-> (state_reg == trta_pkg::ST_PWAIT))
        else $error("heap done outside wait");

endmodule

@@ sv/trta_ram.sv @@
module trta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/trta_heap.sv @@
// Min-heap that keeps the largest "keep" values seen and their running sum.
// One add: push while below keep, else, if the value beats the root, replace the root and sift down.
module trta_heap (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trta_pkg::heap_cmd_t  cmd,
    output trta_pkg::heap_sts_t  sts
);

    trta_pkg::heap_state_t state_reg, state_next;

    logic [trta_pkg::CW-1:0]         count_reg, count_next;
    logic [trta_pkg::SUM_BITS-1:0]   sum_reg, sum_next;
    logic [trta_pkg::SKILL_BITS-1:0] val_reg, val_next;
    logic [trta_pkg::AW-1:0]         pos_reg, pos_next;
    logic [trta_pkg::SKILL_BITS-1:0] hl_reg, hl_next;
    logic [trta_pkg::SKILL_BITS-1:0] hr_reg, hr_next;
    logic                            has_r_reg, has_r_next;

    logic                            h_we;
    logic [trta_pkg::AW-1:0]         h_waddr;
    logic [trta_pkg::SKILL_BITS-1:0] h_wdata;
    logic [trta_pkg::AW-1:0]         h_raddr;
    logic [trta_pkg::SKILL_BITS-1:0] h_rdata;

    logic [trta_pkg::LW-1:0]         left_idx;
    logic [trta_pkg::LW-1:0]         right_idx;
    logic [trta_pkg::LW-1:0]         count_ext;
    logic [trta_pkg::AW-1:0]         parent_idx;
    logic                            below_keep;
    logic                            keep_zero;
    logic                            use_r;
    logic [trta_pkg::SKILL_BITS-1:0] m_val;
    logic [trta_pkg::AW-1:0]         m_idx;

    assign left_idx   = trta_pkg::LW'({pos_reg, 1'b1});
    assign right_idx  = left_idx + trta_pkg::LW'(1);
    assign count_ext  = trta_pkg::LW'(count_reg);
    assign parent_idx = trta_pkg::AW'((pos_reg - trta_pkg::AW'(1)) >> 1);
    assign below_keep = trta_pkg::KW'(count_reg) < trta_pkg::KW'(cmd.keep);
    assign keep_zero  = (cmd.keep == '0);
    assign use_r      = has_r_reg && (hr_reg < hl_reg);
    assign m_val      = use_r ? hr_reg : hl_reg;
    assign m_idx      = use_r ? right_idx[trta_pkg::AW-1:0] : left_idx[trta_pkg::AW-1:0];

    trta_ram #(
        .WIDTH(trta_pkg::SKILL_BITS),
        .DEPTH(trta_pkg::MAX_ITEMS)
    ) u_heap_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trta_pkg::HS_IDLE:
            begin
                if (cmd.add)
                begin
                    if (below_keep)
                        state_next = trta_pkg::HS_UP;
                    else if (keep_zero)
                        state_next = trta_pkg::HS_DONE;
                    else
                        state_next = trta_pkg::HS_ROOT;
                end
            end
            trta_pkg::HS_UP:
                state_next = (pos_reg == '0) ? trta_pkg::HS_DONE : trta_pkg::HS_UPCMP;
            trta_pkg::HS_UPCMP:
                state_next = (h_rdata <= val_reg) ? trta_pkg::HS_DONE : trta_pkg::HS_UP;
            trta_pkg::HS_ROOT:
                state_next = (val_reg <= h_rdata) ? trta_pkg::HS_DONE : trta_pkg::HS_ADDV;
            trta_pkg::HS_ADDV:
                state_next = trta_pkg::HS_DN;
            trta_pkg::HS_DN:
                state_next = (left_idx >= count_ext) ? trta_pkg::HS_DONE : trta_pkg::HS_DNL;
            trta_pkg::HS_DNL:
                state_next = (right_idx < count_ext) ? trta_pkg::HS_DNR : trta_pkg::HS_DNSEL;
            trta_pkg::HS_DNR:
                state_next = trta_pkg::HS_DNSEL;
            trta_pkg::HS_DNSEL:
                state_next = (m_val < val_reg) ? trta_pkg::HS_DN : trta_pkg::HS_DONE;
            trta_pkg::HS_DONE:
                state_next = trta_pkg::HS_IDLE;
            default:
                state_next = trta_pkg::HS_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        hl_next    = hl_reg;
        hr_next    = hr_reg;
        has_r_next = has_r_reg;
        h_we       = 1'b0;
        h_waddr    = pos_reg;
        h_wdata    = val_reg;
        h_raddr    = '0;
        unique case (state_reg)
            trta_pkg::HS_IDLE:
            begin
                if (cmd.clear)
                begin
                    count_next = '0;
                    sum_next   = '0;
                end
                if (cmd.add)
                begin
                    val_next = cmd.value;
                    if (below_keep)
                    begin
                        pos_next   = trta_pkg::AW'(count_reg);
                        count_next = count_reg + trta_pkg::CW'(1);
                        sum_next   = sum_reg + trta_pkg::SUM_BITS'(cmd.value);
                    end
                end
            end
            trta_pkg::HS_UP:
            begin
                if (pos_reg == '0)
                    h_we = 1'b1;
                else
                    h_raddr = parent_idx;
            end
            trta_pkg::HS_UPCMP:
            begin
                h_we = 1'b1;
                if (h_rdata > val_reg)
                begin
                    h_wdata  = h_rdata;
                    pos_next = parent_idx;
                end
            end
            trta_pkg::HS_ROOT:
            begin
                // root is the smallest kept value; it leaves the sum if the new value is larger
                if (val_reg > h_rdata)
                    sum_next = sum_reg - trta_pkg::SUM_BITS'(h_rdata);
            end
            trta_pkg::HS_ADDV:
            begin
                sum_next = sum_reg + trta_pkg::SUM_BITS'(val_reg);
                pos_next = '0;
            end
            trta_pkg::HS_DN:
            begin
                if (left_idx >= count_ext)
                    h_we = 1'b1;
                else
                    h_raddr = left_idx[trta_pkg::AW-1:0];
            end
            trta_pkg::HS_DNL:
            begin
                hl_next    = h_rdata;
                has_r_next = right_idx < count_ext;
                h_raddr    = right_idx[trta_pkg::AW-1:0];
            end
            trta_pkg::HS_DNR:
                hr_next = h_rdata;
            trta_pkg::HS_DNSEL:
            begin
                h_we = 1'b1;
                if (m_val < val_reg)
                begin
                    h_wdata  = m_val;
                    pos_next = m_idx;
                end
            end
            trta_pkg::HS_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trta_pkg::HS_IDLE;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        hl_reg    <= hl_next;
        hr_reg    <= hr_next;
        has_r_reg <= has_r_next;
    end

    assign sts.done = (state_reg == trta_pkg::HS_DONE);
    assign sts.sum  = sum_reg;

endmodule
